[rtl/plom_pkg.sv]
// shared types and codes for the price level order matcher
// used by plom_cell, plom_chain and price_level_order_matcher
package plom_pkg;

  localparam int QTY_W = 31;
  localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

  // order opcodes
  localparam logic [1:0] OP_MKT_BUY = 2'd0;
  localparam logic [1:0] OP_MKT_SELL = 2'd1;
  localparam logic [1:0] OP_LIM_BUY = 2'd2;
  localparam logic [1:0] OP_LIM_SELL = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;

  // command broadcast along a chain
  typedef struct packed {
    logic             pop;
    logic             dec_en;
    logic [QTY_W-1:0] dec_qty;
  } cell_cmd_t;

  // flags of the token that travels down a chain
  typedef struct packed {
    logic vld;     // token carries a level
    logic ins_ok;  // level may take a free cell
    logic rpt;     // token carries a merge or drop report
    logic drop;    // units were dropped
  } tok_ctl_t;

endpackage

[rtl/plom_cell.sv]
// one price level cell of a sorted chain
// depends on plom_pkg
module plom_cell #(
  parameter int PRICE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        descending,
  input  plom_pkg::cell_cmd_t         cmd,
  input  plom_pkg::tok_ctl_t          tin_ctl,
  input  logic [PRICE_BITS-1:0]       tin_price,
  input  logic [plom_pkg::QTY_W-1:0]  tin_qty,
  input  logic                        nb_vld,
  input  logic [PRICE_BITS-1:0]       nb_price,
  input  logic [plom_pkg::QTY_W-1:0]  nb_qty,
  output logic                        ent_vld,
  output logic [PRICE_BITS-1:0]       ent_price,
  output logic [plom_pkg::QTY_W-1:0]  ent_qty,
  output plom_pkg::tok_ctl_t          tout_ctl,
  output logic [PRICE_BITS-1:0]       tout_price,
  output logic [plom_pkg::QTY_W-1:0]  tout_qty
);
  import plom_pkg::*;

  logic                  ent_vld_next;
  logic [PRICE_BITS-1:0] ent_price_next;
  logic [QTY_W-1:0]      ent_qty_next;
  tok_ctl_t              tout_ctl_next;
  logic [PRICE_BITS-1:0] tout_price_next;
  logic [QTY_W-1:0]      tout_qty_next;
  logic                  better;
  logic                  same;
  logic [QTY_W:0]        sum;

  assign better = descending ? (tin_price > ent_price) : (tin_price < ent_price);
  assign same = ent_vld && (ent_price == tin_price);
  assign sum = {1'b0, ent_qty} + {1'b0, tin_qty};

  // shift, decrement, merge or insert, else report a drop or pass the token on
  always_comb begin
    ent_vld_next = ent_vld;
    ent_price_next = ent_price;
    ent_qty_next = ent_qty;
    tout_ctl_next = '0;
    tout_price_next = tin_price;
    tout_qty_next = tin_qty;
    if (cmd.pop) begin
      ent_vld_next = nb_vld;
      ent_price_next = nb_price;
      ent_qty_next = nb_qty;
    end else if (cmd.dec_en) begin
      ent_qty_next = ent_qty - cmd.dec_qty;
    end
    if (tin_ctl.vld) begin
      if (same) begin
        // merge, saturating at the largest quantity
        ent_qty_next = sum[QTY_W] ? QTY_MAX : sum[QTY_W-1:0];
        tout_ctl_next.rpt = 1'b1;
        tout_ctl_next.drop = sum[QTY_W];
        tout_qty_next = sum[QTY_W] ? (QTY_MAX - ent_qty) : tin_qty;
      end else if (!ent_vld || better) begin
        if (tin_ctl.ins_ok) begin
          ent_vld_next = 1'b1;
          ent_price_next = tin_price;
          ent_qty_next = tin_qty;
          tout_ctl_next.vld = ent_vld;
          tout_ctl_next.ins_ok = 1'b1;
          tout_price_next = ent_price;
          tout_qty_next = ent_qty;
        end else begin
          tout_ctl_next.rpt = 1'b1;
          tout_ctl_next.drop = 1'b1;
          tout_qty_next = '0;
        end
      end else begin
        tout_ctl_next = tin_ctl;
      end
    end else if (tin_ctl.rpt) begin
      tout_ctl_next = tin_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= 1'b0;
      tout_ctl <= '0;
    end else begin
      ent_vld <= ent_vld_next;
      tout_ctl <= tout_ctl_next;
    end
    ent_price <= ent_price_next;
    ent_qty <= ent_qty_next;
    tout_price <= tout_price_next;
    tout_qty <= tout_qty_next;
  end

endmodule

[rtl/plom_chain.sv]
// sorted chain of price level cells for one side, best level in cell 0
// depends on plom_pkg and plom_cell
module plom_chain #(
  parameter int BOOK_DEPTH = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        descending,
  input  plom_pkg::cell_cmd_t         cmd,
  input  plom_pkg::tok_ctl_t          tin_ctl,
  input  logic [PRICE_BITS-1:0]       tin_price,
  input  logic [plom_pkg::QTY_W-1:0]  tin_qty,
  output logic                        head_vld,
  output logic [PRICE_BITS-1:0]       head_price,
  output logic [plom_pkg::QTY_W-1:0]  head_qty,
  output plom_pkg::tok_ctl_t          end_ctl,
  output logic [plom_pkg::QTY_W-1:0]  end_qty
);
  import plom_pkg::*;

  logic                  ev [BOOK_DEPTH];
  logic [PRICE_BITS-1:0] ep [BOOK_DEPTH];
  logic [QTY_W-1:0]      eq [BOOK_DEPTH];
  tok_ctl_t              tc [BOOK_DEPTH];
  logic [PRICE_BITS-1:0] tp [BOOK_DEPTH];
  logic [QTY_W-1:0]      tq [BOOK_DEPTH];
  cell_cmd_t             tail_cmd;

  // only the head cell is decremented
  assign tail_cmd = '{pop: cmd.pop, dec_en: 1'b0, dec_qty: '0};

  // row of cells, token moves right, pop shifts left
  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
    cell_cmd_t             c_cmd;
    tok_ctl_t              c_tc;
    logic [PRICE_BITS-1:0] c_tp;
    logic [QTY_W-1:0]      c_tq;
    logic                  n_v;
    logic [PRICE_BITS-1:0] n_p;
    logic [QTY_W-1:0]      n_q;
    if (i == 0) begin : g_head
      assign c_cmd = cmd;
      assign c_tc = tin_ctl;
      assign c_tp = tin_price;
      assign c_tq = tin_qty;
    end else begin : g_body
      assign c_cmd = tail_cmd;
      assign c_tc = tc[i-1];
      assign c_tp = tp[i-1];
      assign c_tq = tq[i-1];
    end
    if (i == BOOK_DEPTH - 1) begin : g_last
      assign n_v = 1'b0;
      assign n_p = '0;
      assign n_q = '0;
    end else begin : g_mid
      assign n_v = ev[i+1];
      assign n_p = ep[i+1];
      assign n_q = eq[i+1];
    end
    plom_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
      .clk(clk), .rst(rst), .descending(descending), .cmd(c_cmd),
      .tin_ctl(c_tc), .tin_price(c_tp), .tin_qty(c_tq),
      .nb_vld(n_v), .nb_price(n_p), .nb_qty(n_q),
      .ent_vld(ev[i]), .ent_price(ep[i]), .ent_qty(eq[i]),
      .tout_ctl(tc[i]), .tout_price(tp[i]), .tout_qty(tq[i])
    );
  end

  assign head_vld = ev[0];
  assign head_price = ep[0];
  assign head_qty = eq[0];
  assign end_ctl = tc[BOOK_DEPTH-1];
  assign end_qty = tq[BOOK_DEPTH-1];

endmodule

[rtl/price_level_order_matcher.sv]
// price level order matcher: a bid chain and an ask chain of level cells
// and the order sequencer; depends on plom_pkg and plom_chain
//
// Usage: orders arrive on the in channel (in_valid/in_stall) with opcode,
// order_quantity and limit_price; one result per order leaves on the out
// channel (out_valid/out_stall). Bids are kept sorted best first in one
// chain of BOOK_DEPTH cells and asks in another, so the best opposite level
// is always at the head cell.
// Steps: the sweep takes opposite levels best first while units remain
// and the price meets the limit. A limit order with units left then sends
// its rest down its own side chain to merge or insert, and the sequencer
// waits for it at the chain's end. Then the result register is loaded.
// A zero quantity order goes straight to the result. The sequencer then
// returns to idle, where it takes the next order.
// One order is in work at a time; the next may be taken while the last
// result still waits. When the receiver stalls, the result holds and the
// following order waits at its end.
// Reset empties the book; the result outputs, best prices included, are not reset.
module price_level_order_matcher #(
  parameter int BOOK_DEPTH = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [plom_pkg::QTY_W-1:0]  order_quantity,
  input  logic [31:0]                 limit_price,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [plom_pkg::QTY_W-1:0]  filled_quantity,
  output logic [63:0]                 fill_notional,
  output logic [plom_pkg::QTY_W-1:0]  rested_quantity,
  output logic [31:0]                 best_bid,
  output logic [31:0]                 best_ask,
  output logic [1:0]                  status
);
  import plom_pkg::*;

  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int WW = $clog2(BOOK_DEPTH);
  localparam int MW = PRICE_BITS + QTY_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_REST = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state;
  logic                  buy;
  logic                  lim;
  logic [QTY_W-1:0]      rem;
  logic [PRICE_BITS-1:0] lp;
  logic [QTY_W-1:0]      filled;
  logic [63:0]           notional;
  logic [63:0]           prod;
  logic                  prod_vld;
  logic [QTY_W-1:0]      rested;
  logic [1:0]            st;
  logic [CW-1:0]         cnt;
  logic [WW-1:0]         wcnt;

  logic                  bid_vld, ask_vld;
  logic [PRICE_BITS-1:0] bid_price, ask_price;
  logic [QTY_W-1:0]      bid_qty, ask_qty;
  tok_ctl_t              bid_end, ask_end;
  logic [QTY_W-1:0]      bid_end_qty, ask_end_qty;
  cell_cmd_t             bid_cmd, ask_cmd;
  tok_ctl_t              bid_tin, ask_tin, tok;

  logic                  h_vld;
  logic [PRICE_BITS-1:0] h_price;
  logic [QTY_W-1:0]      h_qty;
  logic [QTY_W-1:0]      take;
  logic                  lim_ok;
  logic                  go;
  logic                  pop;
  logic                  inject;
  logic [MW-1:0]         mul;
  logic [64:0]           acc;
  logic [63:0]           notional_next;
  tok_ctl_t              own_end;
  logic [QTY_W-1:0]      own_end_qty;

  // best opposite level and how much of it is taken
  assign h_vld = buy ? ask_vld : bid_vld;
  assign h_price = buy ? ask_price : bid_price;
  assign h_qty = buy ? ask_qty : bid_qty;
  assign take = (rem < h_qty) ? rem : h_qty;
  assign lim_ok = !lim || (buy ? (h_price <= lp) : (h_price >= lp));
  assign go = (state == S_SWEEP) && h_vld && (rem != '0) && lim_ok;
  assign pop = go && (take == h_qty);
  assign inject = (state == S_SWEEP) && !go && lim && (rem != '0);
  assign mul = MW'(h_price) * MW'(take);

  // saturating notional sum
  assign acc = {1'b0, notional} + {1'b0, prod};
  assign notional_next = acc[64] ? {64{1'b1}} : acc[63:0];

  // chain commands
  assign ask_cmd = '{pop: pop && buy, dec_en: go && !pop && buy, dec_qty: take};
  assign bid_cmd = '{pop: pop && !buy, dec_en: go && !pop && !buy, dec_qty: take};
  assign tok = '{vld: inject, ins_ok: (cnt < CW'(BOOK_DEPTH)), rpt: 1'b0, drop: 1'b0};
  assign bid_tin = buy ? tok : '0;
  assign ask_tin = buy ? '0 : tok;
  assign own_end = buy ? bid_end : ask_end;
  assign own_end_qty = buy ? bid_end_qty : ask_end_qty;

  plom_chain #(.BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS)) u_bid (
    .clk(clk), .rst(rst), .descending(1'b1), .cmd(bid_cmd),
    .tin_ctl(bid_tin), .tin_price(lp), .tin_qty(rem),
    .head_vld(bid_vld), .head_price(bid_price), .head_qty(bid_qty),
    .end_ctl(bid_end), .end_qty(bid_end_qty)
  );

  plom_chain #(.BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS)) u_ask (
    .clk(clk), .rst(rst), .descending(1'b0), .cmd(ask_cmd),
    .tin_ctl(ask_tin), .tin_price(lp), .tin_qty(rem),
    .head_vld(ask_vld), .head_price(ask_price), .head_qty(ask_qty),
    .end_ctl(ask_end), .end_qty(ask_end_qty)
  );

  assign in_stall = (state != S_IDLE);

  // order sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prod_vld <= 1'b0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      // result handshake
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (order_quantity == '0) ? S_DONE : S_SWEEP;
            st <= (order_quantity == '0) ? ST_ZERO : ST_DONE;
          end
        end
        S_SWEEP: begin
          prod_vld <= go;
          if (prod_vld) begin
            notional <= notional_next;
          end
          if (go) begin
            prod <= 64'(mul);
            rem <= rem - take;
            filled <= filled + take;
            if (pop) begin
              cnt <= cnt - 1'b1;
            end
          end else if (inject) begin
            wcnt <= WW'(BOOK_DEPTH - 1);
            state <= S_REST;
          end else begin
            state <= S_DONE;
          end
        end
        S_REST: begin
          if (wcnt == '0) begin
            state <= S_DONE;
            if (own_end.rpt) begin
              rested <= own_end_qty;
              st <= own_end.drop ? ST_DROP : ST_DONE;
            end else if (own_end.vld) begin
              // full side with every level better, the rest falls off the end
              rested <= '0;
              st <= ST_DROP;
            end else begin
              rested <= rem;
              cnt <= cnt + 1'b1;
            end
          end else begin
            wcnt <= wcnt - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    // order capture
    if (state == S_IDLE && in_valid) begin
      buy <= opcode inside {OP_MKT_BUY, OP_LIM_BUY};
      lim <= opcode inside {OP_LIM_BUY, OP_LIM_SELL};
      rem <= order_quantity;
      lp <= limit_price[PRICE_BITS-1:0];
      filled <= '0;
      notional <= '0;
      rested <= '0;
    end
    // result register
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      filled_quantity <= filled;
      fill_notional <= notional;
      rested_quantity <= rested;
      best_bid <= bid_vld ? 32'(bid_price) : 32'd0;
      best_ask <= ask_vld ? 32'(ask_price) : 32'd0;
      status <= st;
    end
  end

  // the level count of both sides together never exceeds BOOK_DEPTH
  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(BOOK_DEPTH))
    else $error("level count above book depth");

  // a level is only removed when one is present
  assert property (@(posedge clk) disable iff (rst) pop |-> h_vld)
    else $error("pop of an empty chain");

  // a rest report only appears at the end of the rest wait
  assert property (@(posedge clk) disable iff (rst)
    (bid_end.rpt || ask_end.rpt) |-> (state == S_REST && wcnt == '0))
    else $error("rest report outside its slot");

  // an ignored order fills and rests nothing
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ZERO) |-> (filled_quantity == '0 && rested_quantity == '0))
    else $error("zero quantity order changed quantities");

endmodule

[verif/price_level_order_matcher_chk.sv]
// checker for the price level order matcher: watches both channels, keeps
// its own copy of the book and compares every result; depends on plom_pkg
module price_level_order_matcher_chk #(
  parameter int BOOK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [30:0] order_quantity,
  input  logic [31:0] limit_price,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [30:0] filled_quantity,
  input  logic [63:0] fill_notional,
  input  logic [30:0] rested_quantity,
  input  logic [31:0] best_bid,
  input  logic [31:0] best_ask,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending_count,
  output int          fill_count,
  output int          drop_count
);
  import plom_pkg::*;

  localparam int RQ_DEPTH = 8;

  typedef struct packed {
    logic [30:0] filled;
    logic [63:0] notional;
    logic [30:0] rested;
    logic [31:0] bid;
    logic [31:0] ask;
    logic [1:0]  st;
  } fill_report_t;

  // shadow book
  logic        lvl_on   [BOOK_DEPTH];
  logic        lvl_sell [BOOK_DEPTH];
  logic [31:0] lvl_px   [BOOK_DEPTH];
  logic [30:0] lvl_qty  [BOOK_DEPTH];
  logic [31:0] cur_bid, cur_ask;

  // expected results in order, oldest at rd_ptr
  fill_report_t report_mem [RQ_DEPTH];
  logic [2:0]   rd_ptr, wr_ptr;
  int           held;

  // best opposite level the order may take, -1 if none
  function automatic int best_opposite(logic buy, logic lim, logic [31:0] lp);
    int b;
    b = -1;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (!lvl_on[i] || lvl_sell[i] != buy) continue;
      if (lim && (buy ? lvl_px[i] > lp : lvl_px[i] < lp)) continue;
      if (b < 0 || (buy ? lvl_px[i] < lvl_px[b] : lvl_px[i] > lvl_px[b])) b = i;
    end
    return b;
  endfunction

  function automatic fill_report_t match_order(logic [1:0] op, logic [30:0] qty,
                                               logic [31:0] lp);
    fill_report_t r;
    logic buy, lim, have_ask;
    logic [30:0] rem, take, room;
    logic [63:0] prod;
    int k, hit, slot;
    buy = (op == OP_MKT_BUY || op == OP_LIM_BUY);
    lim = (op == OP_LIM_BUY || op == OP_LIM_SELL);
    rem = qty;
    r = '0;
    r.st = ST_DONE;
    if (rem == 0) begin
      r.st = ST_ZERO;
    end else begin
      // sweep opposite levels
      for (int n = 0; n < BOOK_DEPTH && rem > 0; n++) begin
        k = best_opposite(buy, lim, lp);
        if (k < 0) break;
        take = rem < lvl_qty[k] ? rem : lvl_qty[k];
        prod = 64'(lvl_px[k]) * 64'(take);
        r.notional = (r.notional > ~64'd0 - prod) ? ~64'd0 : r.notional + prod;
        r.filled += take;
        rem -= take;
        if (take == lvl_qty[k]) lvl_on[k] = 1'b0;
        else lvl_qty[k] -= take;
      end
      // rest the remainder
      if (lim && rem > 0) begin
        hit = -1;
        slot = -1;
        for (int i = 0; i < BOOK_DEPTH; i++) begin
          if (lvl_on[i]) begin
            if (hit < 0 && lvl_sell[i] == !buy && lvl_px[i] == lp) hit = i;
          end else if (slot < 0) begin
            slot = i;
          end
        end
        if (hit >= 0) begin
          room = QTY_MAX - lvl_qty[hit];
          r.rested = rem < room ? rem : room;
          lvl_qty[hit] += r.rested;
          if (r.rested != rem) r.st = ST_DROP;
        end else if (slot >= 0) begin
          lvl_on[slot] = 1'b1;
          lvl_sell[slot] = !buy;
          lvl_px[slot] = lp;
          lvl_qty[slot] = rem;
          r.rested = rem;
        end else begin
          r.st = ST_DROP;
        end
      end
      // recompute best prices
      cur_bid = 0;
      cur_ask = 0;
      have_ask = 1'b0;
      for (int i = 0; i < BOOK_DEPTH; i++) begin
        if (!lvl_on[i]) continue;
        if (lvl_sell[i]) begin
          if (!have_ask || lvl_px[i] < cur_ask) begin
            cur_ask = lvl_px[i];
            have_ask = 1'b1;
          end
        end else if (lvl_px[i] > cur_bid) begin
          cur_bid = lvl_px[i];
        end
      end
    end
    r.bid = cur_bid;
    r.ask = cur_ask;
    return r;
  endfunction

  task automatic cmp_field(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: mismatch on %s expected %0d actual %0d", $time, nm, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    fill_report_t exp_r;
    if (rst) begin
      for (int i = 0; i < BOOK_DEPTH; i++) begin
        lvl_on[i] = 1'b0;
        lvl_sell[i] = 1'b0;
        lvl_px[i] = '0;
        lvl_qty[i] = '0;
      end
      cur_bid = '0;
      cur_ask = '0;
      rd_ptr = '0;
      wr_ptr = '0;
      held = 0;
      fail_count = 0;
      fill_count = 0;
      drop_count = 0;
    end else begin
      // output transaction first: its expectation is always older
      if (out_valid && !out_stall) begin
        if (held == 0) begin
          $display("%0t: unexpected result transaction", $time);
          fail_count++;
        end else begin
          exp_r = report_mem[rd_ptr];
          rd_ptr = rd_ptr + 3'd1;
          held--;
          cmp_field("filled_quantity", exp_r.filled, filled_quantity);
          cmp_field("fill_notional", exp_r.notional, fill_notional);
          cmp_field("rested_quantity", exp_r.rested, rested_quantity);
          cmp_field("best_bid", exp_r.bid, best_bid);
          cmp_field("best_ask", exp_r.ask, best_ask);
          cmp_field("status", exp_r.st, status);
        end
      end
      if (in_valid && !in_stall) begin
        exp_r = match_order(opcode, order_quantity, limit_price);
        if (exp_r.filled != 0) fill_count++;
        if (exp_r.st == ST_DROP) drop_count++;
        if (held == RQ_DEPTH) begin
          $display("%0t: too many transactions without a result", $time);
          fail_count++;
        end else begin
          report_mem[wr_ptr] = exp_r;
          wr_ptr = wr_ptr + 3'd1;
          held++;
        end
      end
    end
  end

  assign pending_count = held;
endmodule

[verif/price_level_order_matcher_tb.sv]
// testbench top for the price level order matcher: drives orders, stalls
// results and gives the verdict; depends on the block and its checker
module price_level_order_matcher_tb;
  import plom_pkg::*;

  localparam int DEPTH = 64;
  localparam int N_RAND = 1300;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [1:0]  opcode;
  logic [30:0] order_quantity;
  logic [31:0] limit_price;
  logic [30:0] filled_quantity, rested_quantity;
  logic [63:0] fill_notional;
  logic [31:0] best_bid, best_ask;
  logic [1:0]  status;
  int          fail_count, pending_count, fill_count, drop_count;
  logic        calm;
  int          sent;

  price_level_order_matcher #(.BOOK_DEPTH(DEPTH), .PRICE_BITS(32)) dut (.*);

  price_level_order_matcher_chk #(.BOOK_DEPTH(DEPTH)) chk (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver stalls in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // present one order and wait for its transaction
  task automatic send_order(logic [1:0] op, logic [30:0] q, logic [31:0] p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    order_quantity <= q;
    limit_price <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic rand_order();
    logic [1:0] op;
    logic [30:0] q;
    logic [31:0] p;
    int mode;
    op = 2'($urandom_range(0, 3));
    mode = $urandom_range(0, 19);
    // mostly small quantities near a mid price so levels cross and merge
    if (mode < 14) q = 31'($urandom_range(1, 200));
    else if (mode < 16) q = 31'($urandom);
    else if (mode < 17) q = QTY_MAX - 31'($urandom_range(0, 3));
    else if (mode < 18) q = 0;
    else q = 31'($urandom_range(1, 5000));
    mode = $urandom_range(0, 9);
    if (mode < 8) p = 32'($urandom_range(990, 1010));
    else if (mode < 9) p = $urandom;
    else p = ($urandom_range(0, 1)) ? 32'hFFFF_FFFF : 32'd0;
    send_order(op, q, p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_MKT_BUY;
    order_quantity = '0;
    limit_price = '0;
    calm = 1'b0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty book, zero quantity, price extremes, merge overflow
    send_order(OP_MKT_BUY, 31'd10, 32'd0);
    send_order(OP_MKT_SELL, 31'd10, 32'd0);
    send_order(OP_LIM_BUY, 31'd0, 32'd100);
    send_order(OP_LIM_BUY, 31'd5, 32'd0);
    send_order(OP_LIM_SELL, 31'd7, 32'hFFFF_FFFF);
    send_order(OP_LIM_BUY, 31'd3, 32'd100);
    send_order(OP_LIM_SELL, 31'd4, 32'd200);
    send_order(OP_LIM_BUY, QTY_MAX, 32'd100);
    send_order(OP_LIM_BUY, QTY_MAX, 32'd100);
    send_order(OP_MKT_BUY, QTY_MAX, 32'd0);
    send_order(OP_LIM_SELL, 31'd2, 32'd50);
    send_order(OP_MKT_SELL, QTY_MAX, 32'd0);
    send_order(OP_LIM_SELL, QTY_MAX, 32'hFFFF_FFFF);
    send_order(OP_MKT_BUY, QTY_MAX, 32'd0);
    send_order(OP_LIM_SELL, 31'h2AAA_AAAA, 32'h5555_5555);
    send_order(OP_LIM_BUY, 31'h5555_5555, 32'hAAAA_AAAA);
    drain();

    // fill the book with distinct bids, then overflow it
    for (int i = 0; i < DEPTH + 3; i++) send_order(OP_LIM_BUY, 31'd1, 32'(i + 1));
    send_order(OP_LIM_SELL, 31'd5, 32'hFFFF_FFFF);
    send_order(OP_LIM_SELL, 31'd5, 32'd30);
    send_order(OP_MKT_SELL, QTY_MAX, 32'd0);
    drain();

    // random orders; last part without random gaps or stalls
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND - 200) calm = 1'b1;
      if (i % 300 == 299) drain();
      rand_order();
    end
    drain();

    $display("orders sent %0d, with fills %0d, with dropped rest %0d",
             sent, fill_count, drop_count);
    $display("covered market and limit orders, merges, full book and extremes");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end
endmodule

[sim.f]
rtl/plom_pkg.sv
rtl/plom_cell.sv
rtl/plom_chain.sv
rtl/price_level_order_matcher.sv
verif/price_level_order_matcher_chk.sv
verif/price_level_order_matcher_tb.sv
